>>> sv/midi_event_stream_parser_core_defines.svh
// Assertion macros for the MIDI event stream parser.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef MIDI_EVENT_STREAM_PARSER_CORE_DEFINES_SVH
`define MIDI_EVENT_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MESP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MESP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mesp_pkg.sv
// Shared types and constants for the MIDI event stream parser.
// No dependencies; used by every module of the block.
`default_nettype none

package mesp_pkg;

	typedef enum logic [2:0] {
		PH_EVENT    = 3'd0,
		PH_DATA1    = 3'd1,
		PH_DATA2    = 3'd2,
		PH_SKIPLEN1 = 3'd3,
		PH_SKIPLEN2 = 3'd4,
		PH_SKIP     = 3'd5,
		PH_DELTA1   = 3'd6,
		PH_DELTA2   = 3'd7
	} phase_t;

	localparam logic [1:0] KIND_MSG  = 2'd0;
	localparam logic [1:0] KIND_WAIT = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic CFG_NOTES_MUTED = 1'b0;
	localparam logic CFG_TICK_SCALE  = 1'b1;

	localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
	localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
	localparam logic [7:0] STATUS_META   = 8'hFF;
	localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
	localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
	localparam logic [3:0] TYPE_PRESSURE = 4'hD;

	localparam int CFG_DATA_W = 7;
	localparam int DELTA_W    = 14;
	localparam int WAIT_W     = 21;
	localparam logic [CFG_DATA_W-1:0] TICK_SCALE_RST = 7'd10;

	typedef struct packed {
		logic [7:0] track_byte;
		logic       track_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [23:0]       short_message;
		logic [WAIT_W-1:0] wait_ms;
	} out_item_t;

	typedef struct packed {
		logic      fire;
		out_item_t item;
	} result_t;

endpackage

`default_nettype wire

>>> sv/mesp_in_stage.sv
// Input register of the parser: holds one byte beat until the parser takes it.
// Depends on mesp_pkg.
`default_nettype none

module mesp_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mesp_pkg::in_item_t in_data,
	input  wire logic              advance,
	output logic                   valid_s1,
	output mesp_pkg::in_item_t     data_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

>>> sv/mesp_parser.sv
// Parse state machine: running status, skip and delta decoding, result forming.
// Depends on mesp_pkg.
`default_nettype none

module mesp_parser (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               advance,
	input  wire mesp_pkg::in_item_t                 data_s1,
	input  wire logic                               notes_muted,
	input  wire logic [mesp_pkg::CFG_DATA_W-1:0]    tick_scale,
	output mesp_pkg::result_t                       result
);

	mesp_pkg::phase_t phase_q, phase_n, phase_eff;
	logic [7:0]  status_q, status_n, status_eff;
	logic [15:0] acc_q, acc_n;
	logic [7:0]  vlen_q, vlen_n;
	logic [mesp_pkg::DELTA_W-1:0] skip_q, skip_n, skip_len;
	logic [mesp_pkg::DELTA_W-1:0] delta;
	logic [7:0]  b;
	logic        is_data, one_data, status_muted, acc_muted, skip_status;
	logic [mesp_pkg::WAIT_W-1:0] wait_prod;

	assign b         = data_s1.track_byte;
	assign is_data   = !b[7];
	assign phase_eff = data_s1.track_start ? mesp_pkg::PH_EVENT : phase_q;
	assign status_eff = (phase_eff == mesp_pkg::PH_EVENT && !is_data) ? b : status_q;

	assign one_data = status_eff[7:4] == mesp_pkg::TYPE_PROGRAM
		|| status_eff[7:4] == mesp_pkg::TYPE_PRESSURE;
	assign status_muted = notes_muted && (status_eff[7:4] == mesp_pkg::TYPE_NOTE_OFF
		|| status_eff[7:4] == mesp_pkg::TYPE_NOTE_ON);
	assign acc_muted = notes_muted && (acc_q[7:4] == mesp_pkg::TYPE_NOTE_OFF
		|| acc_q[7:4] == mesp_pkg::TYPE_NOTE_ON);
	assign skip_status = status_eff == mesp_pkg::STATUS_SYSEX
		|| status_eff == mesp_pkg::STATUS_ESCAPE;

	// Two-byte length for a skip block: high seven bits from this byte.
	assign skip_len = {b[6:0], vlen_q[6:0]};
	assign delta = (phase_eff == mesp_pkg::PH_DELTA1) ? {7'd0, b[6:0]} : {b[6:0], vlen_q[6:0]};
	assign wait_prod = {7'd0, delta} * {14'd0, tick_scale};

	// Next state.
	always_comb begin
		phase_n  = phase_eff;
		status_n = status_eff;
		acc_n    = acc_q;
		vlen_n   = vlen_q;
		skip_n   = skip_q;
		case (phase_eff)
			mesp_pkg::PH_EVENT, mesp_pkg::PH_DATA1: begin
				if (phase_eff == mesp_pkg::PH_EVENT && skip_status) begin
					if (!is_data) begin
						phase_n = mesp_pkg::PH_SKIPLEN1;
					end else begin
						skip_n  = {7'd0, b[6:0]};
						phase_n = (b[6:0] == 7'd0) ? mesp_pkg::PH_DELTA1 : mesp_pkg::PH_SKIP;
					end
				end else if (phase_eff == mesp_pkg::PH_EVENT
						&& status_eff == mesp_pkg::STATUS_META) begin
					phase_n = mesp_pkg::PH_EVENT;
				end else if (phase_eff == mesp_pkg::PH_EVENT && !is_data) begin
					phase_n = mesp_pkg::PH_DATA1;
				end else begin
					acc_n   = {b, status_eff};
					phase_n = one_data ? mesp_pkg::PH_DELTA1 : mesp_pkg::PH_DATA2;
				end
			end
			mesp_pkg::PH_DATA2: begin
				phase_n = b[7] ? mesp_pkg::PH_EVENT : mesp_pkg::PH_DELTA1;
			end
			mesp_pkg::PH_SKIPLEN1: begin
				if (b[7]) begin
					vlen_n  = b;
					phase_n = mesp_pkg::PH_SKIPLEN2;
				end else begin
					skip_n  = {7'd0, b[6:0]};
					phase_n = (b[6:0] == 7'd0) ? mesp_pkg::PH_DELTA1 : mesp_pkg::PH_SKIP;
				end
			end
			mesp_pkg::PH_SKIPLEN2: begin
				skip_n  = skip_len;
				phase_n = (skip_len == '0) ? mesp_pkg::PH_DELTA1 : mesp_pkg::PH_SKIP;
			end
			mesp_pkg::PH_SKIP: begin
				skip_n = skip_q - 1'b1;
				if (skip_n == '0) begin
					phase_n = mesp_pkg::PH_DELTA1;
				end
			end
			mesp_pkg::PH_DELTA1: begin
				if (b[7]) begin
					vlen_n  = b;
					phase_n = mesp_pkg::PH_DELTA2;
				end else begin
					phase_n = mesp_pkg::PH_EVENT;
				end
			end
			mesp_pkg::PH_DELTA2: begin
				phase_n = mesp_pkg::PH_EVENT;
			end
			default: begin
				phase_n = mesp_pkg::PH_EVENT;
			end
		endcase
	end

	// Result for the current beat.
	always_comb begin
		result = '0;
		case (phase_eff)
			mesp_pkg::PH_EVENT: begin
				if (!skip_status && status_eff == mesp_pkg::STATUS_META) begin
					result.fire             = 1'b1;
					result.item.result_kind = mesp_pkg::KIND_END;
				end else if (!skip_status && is_data && one_data && !status_muted) begin
					result.fire               = 1'b1;
					result.item.result_kind   = mesp_pkg::KIND_MSG;
					result.item.short_message = {8'd0, b, status_eff};
				end
			end
			mesp_pkg::PH_DATA1: begin
				if (one_data && !status_muted) begin
					result.fire               = 1'b1;
					result.item.result_kind   = mesp_pkg::KIND_MSG;
					result.item.short_message = {8'd0, b, status_eff};
				end
			end
			mesp_pkg::PH_DATA2: begin
				if (!acc_muted) begin
					result.fire               = 1'b1;
					result.item.result_kind   = mesp_pkg::KIND_MSG;
					result.item.short_message = {1'b0, b[6:0], acc_q};
				end
			end
			mesp_pkg::PH_DELTA1, mesp_pkg::PH_DELTA2: begin
				if ((phase_eff == mesp_pkg::PH_DELTA2 || !b[7]) && delta != '0) begin
					result.fire             = 1'b1;
					result.item.result_kind = mesp_pkg::KIND_WAIT;
					result.item.wait_ms     = wait_prod;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mesp_pkg::PH_EVENT;
			status_q <= '0;
			acc_q    <= '0;
			vlen_q   <= '0;
			skip_q   <= '0;
		end else if (advance) begin
			phase_q  <= phase_n;
			status_q <= status_n;
			acc_q    <= acc_n;
			vlen_q   <= vlen_n;
			skip_q   <= skip_n;
		end
	end

endmodule

`default_nettype wire

>>> sv/mesp_out_stage.sv
// Result register: holds a result beat until the sink takes it.
// Depends on mesp_pkg.
`default_nettype none

module mesp_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire mesp_pkg::result_t  result,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mesp_pkg::out_item_t     out_data
);

	mesp_pkg::out_item_t data_q;
	logic                valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result.fire;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.fire) begin
			data_q <= result.item;
		end
	end

endmodule

`default_nettype wire

>>> sv/midi_event_stream_parser_core.sv
// MIDI track event parser with running status, one track byte per beat.
// Path: an accepted byte waits in the input register; its result is then written to the result register.
// Throughput: one byte per cycle; a stalled result register holds the input register.
// Each byte is decoded by one pass of logic between the input and result registers.
// Reset (arst_n low, asynchronous): parser expects an event, running status 0,
// notes_muted 0, tick_scale 10, both registers empty.
`default_nettype none
`include "midi_event_stream_parser_core_defines.svh"

module midi_event_stream_parser_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire mesp_pkg::in_item_t               in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output mesp_pkg::out_item_t                   out_data,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [mesp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic                            notes_muted_q;
	logic [mesp_pkg::CFG_DATA_W-1:0] tick_scale_q;
	logic                            valid_s1;
	mesp_pkg::in_item_t              data_s1;
	logic                            free;
	logic                            advance;
	mesp_pkg::result_t               result;

	assign advance = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notes_muted_q <= 1'b0;
			tick_scale_q  <= mesp_pkg::TICK_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mesp_pkg::CFG_NOTES_MUTED: notes_muted_q <= cfg_wdata[0];
				mesp_pkg::CFG_TICK_SCALE:  tick_scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mesp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	mesp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_s1     (data_s1),
		.notes_muted (notes_muted_q),
		.tick_scale  (tick_scale_q),
		.result      (result)
	);

	mesp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Hold the buffered byte while the result register is blocked.
	`MESP_ASSERT_NEXT(a_hold_s1, valid_s1 && out_valid && !out_ready, valid_s1,
		"input beat dropped while result stalled")
	`MESP_ASSERT_NEXT(a_take_s1, in_valid && in_ready, valid_s1,
		"accepted beat not buffered")
	`MESP_ASSERT_NOW(a_msg_only, out_valid && out_data.result_kind != mesp_pkg::KIND_MSG,
		out_data.short_message == '0, "message field set in non-message result")
	`MESP_ASSERT_NOW(a_wait_only, out_valid && out_data.result_kind != mesp_pkg::KIND_WAIT,
		out_data.wait_ms == '0, "wait field set in non-wait result")

endmodule

`default_nettype wire

>>> tb/sv/midi_result_checker.sv
// Result checker for the MIDI event stream parser: watches the byte and result channels.
// Keeps its own copy of the parser state, predicts each result and compares it in order.
// Depends on mesp_pkg for the payload types, phase codes, result kinds and register indexes.

module midi_result_checker
	import mesp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending,
	output int                    msg_count,
	output int                    wait_count,
	output int                    end_count
);

	phase_t                phase;
	logic [7:0]            run_status;
	logic [15:0]           msg_acc;
	logic [7:0]            vlen_first;
	logic [DELTA_W-1:0]    skip_left;
	logic                  muted;
	logic [CFG_DATA_W-1:0] scale;

	out_item_t expected_results[$];
	out_item_t predicted;
	out_item_t oldest;

	// Drop note off / note on while muted.
	function automatic bit send_message(input logic [23:0] msg, output out_item_t res);
		res = '0;
		if (muted && (msg[7:4] == TYPE_NOTE_OFF || msg[7:4] == TYPE_NOTE_ON))
			return 1'b0;
		res.result_kind   = KIND_MSG;
		res.short_message = msg;
		return 1'b1;
	endfunction

	function automatic bit finish_delta(input logic [DELTA_W-1:0] delta, output out_item_t res);
		res   = '0;
		phase = PH_EVENT;
		if (delta == '0)
			return 1'b0;
		res.result_kind = KIND_WAIT;
		res.wait_ms     = WAIT_W'(delta) * WAIT_W'(scale);
		return 1'b1;
	endfunction

	function automatic void start_skip(input logic [DELTA_W-1:0] len);
		skip_left = len;
		phase     = (len == '0) ? PH_DELTA1 : PH_SKIP;
	endfunction

	function automatic void skip_length_first(input logic [7:0] b);
		if (b[7]) begin
			vlen_first = b;
			phase      = PH_SKIPLEN2;
		end else
			start_skip(DELTA_W'(b));
	endfunction

	// Program change and channel pressure complete on their single data byte.
	function automatic bit take_first_data(input logic [7:0] b, output out_item_t res);
		res     = '0;
		msg_acc = {b, run_status};
		if (run_status[7:4] == TYPE_PROGRAM || run_status[7:4] == TYPE_PRESSURE) begin
			phase = PH_DELTA1;
			return send_message({8'h00, msg_acc}, res);
		end
		phase = PH_DATA2;
		return 1'b0;
	endfunction

	function automatic bit parse_byte(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		b   = it.track_byte;
		res = '0;
		if (it.track_start)
			phase = PH_EVENT;
		case (phase)
		PH_EVENT: begin
			if (b[7])
				run_status = b;
			if (run_status == STATUS_SYSEX || run_status == STATUS_ESCAPE) begin
				if (b[7])
					phase = PH_SKIPLEN1;
				else
					skip_length_first(b);
			end else if (run_status == STATUS_META) begin
				phase           = PH_EVENT;
				res.result_kind = KIND_END;
				return 1'b1;
			end else if (b[7])
				phase = PH_DATA1;
			else
				return take_first_data(b, res);
		end
		PH_DATA1: return take_first_data(b, res);
		PH_DATA2: begin
			// top bit of the second data byte ends the event without a delta
			phase = b[7] ? PH_EVENT : PH_DELTA1;
			return send_message({1'b0, b[6:0], msg_acc}, res);
		end
		PH_SKIPLEN1: skip_length_first(b);
		PH_SKIPLEN2: start_skip({b[6:0], vlen_first[6:0]});
		PH_SKIP: begin
			skip_left = skip_left - 1'b1;
			if (skip_left == '0)
				phase = PH_DELTA1;
		end
		PH_DELTA1: begin
			if (!b[7])
				return finish_delta(DELTA_W'(b), res);
			vlen_first = b;
			phase      = PH_DELTA2;
		end
		default: return finish_delta({b[6:0], vlen_first[6:0]}, res);
		endcase
		return 1'b0;
	endfunction

	// Compare before predicting so a result never meets the expectation of the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase      = PH_EVENT;
			run_status = '0;
			msg_acc    = '0;
			vlen_first = '0;
			skip_left  = '0;
			muted      = 1'b0;
			scale      = TICK_SCALE_RST;
			expected_results.delete();
			fail_count = 0;
			pending    = 0;
			msg_count  = 0;
			wait_count = 0;
			end_count  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: kind %0d msg %06h wait %0d",
						out_data.result_kind, out_data.short_message, out_data.wait_ms);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (out_data.result_kind !== oldest.result_kind) begin
						$error("result_kind: expected %0d, got %0d",
							oldest.result_kind, out_data.result_kind);
						fail_count++;
					end
					if (out_data.short_message !== oldest.short_message) begin
						$error("short_message: expected %06h, got %06h",
							oldest.short_message, out_data.short_message);
						fail_count++;
					end
					if (out_data.wait_ms !== oldest.wait_ms) begin
						$error("wait_ms: expected %0d, got %0d",
							oldest.wait_ms, out_data.wait_ms);
						fail_count++;
					end
					case (oldest.result_kind)
					KIND_MSG:  msg_count++;
					KIND_WAIT: wait_count++;
					default:   end_count++;
					endcase
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_NOTES_MUTED: muted = cfg_wdata[0];
				CFG_TICK_SCALE:  scale = cfg_wdata;
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (parse_byte(in_data, predicted))
					expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/sv/tb_midi_event_stream_parser_core.sv
// Top of the MIDI event stream parser testbench: clock, reset, byte stimulus and verdict.
// Depends on mesp_pkg, midi_event_stream_parser_core and midi_result_checker.

module tb_midi_event_stream_parser_core;
	import mesp_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 64;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = CFG_NOTES_MUTED;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int msg_count;
	int wait_count;
	int end_count;

	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         hold_req      = 1'b0;
	int         bytes_sent    = 0;
	logic [7:0] last_status   = 8'h90;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	midi_event_stream_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	midi_result_checker parse_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.msg_count  (msg_count),
		.wait_count (wait_count),
		.end_count  (end_count)
	);

	// Result side; a hold request keeps ready low for a fixed stretch.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#3000000;
		$display("tb_midi_event_stream_parser_core failed");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input logic st = 1'b0);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{track_byte: b, track_start: st};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Drop valid and wait until every expected result is out and the pipe is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] wval);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= wval;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_delta();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			push_byte(8'h00);
		else if (pick < 75)
			push_byte(8'($urandom_range(127, 1)));
		else begin
			push_byte(8'($urandom_range(255, 128)));
			push_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic push_channel_event();
		logic [7:0] status;
		logic [7:0] d;
		if ($urandom_range(99) < 30 && last_status[7] && last_status[7:4] != 4'hF)
			status = last_status;
		else begin
			status = 8'($urandom_range(8'hEF, 8'h80));
			push_byte(status, $urandom_range(99) < 4);
			last_status = status;
		end
		d = ($urandom_range(99) < 6) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127));
		push_byte(d);
		if (status[7:4] != TYPE_PROGRAM && status[7:4] != TYPE_PRESSURE) begin
			d = ($urandom_range(99) < 6) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127));
			push_byte(d);
			if (d[7])
				return;
		end
		push_delta();
	endtask

	// System exclusive or escape block with a one- or two-byte length.
	task automatic push_block();
		int         len;
		logic [6:0] lo;
		logic       hi;
		if ($urandom_range(99) < 25 && (last_status == STATUS_SYSEX || last_status == STATUS_ESCAPE))
			;
		else begin
			last_status = $urandom_range(1) ? STATUS_SYSEX : STATUS_ESCAPE;
			push_byte(last_status, $urandom_range(99) < 4);
		end
		lo = 7'($urandom_range(5));
		if ($urandom_range(99) < 70) begin
			push_byte({1'b0, lo});
			len = lo;
		end else begin
			hi = ($urandom_range(99) < 8);
			push_byte({1'b1, lo});
			push_byte({1'($urandom_range(1)), 6'b0, hi});
			len = hi * 128 + lo;
		end
		repeat (len) push_byte(8'($urandom_range(255)));
		push_delta();
	endtask

	task automatic run_random(input int count);
		int         stop_at;
		int         pick;
		logic [7:0] b;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 62)
				push_channel_event();
			else if (pick < 74)
				push_block();
			else if (pick < 79) begin
				push_byte(STATUS_META);
				last_status = STATUS_META;
				if ($urandom_range(1))
					push_byte(8'($urandom_range(127)));
			end else if (pick < 85) begin
				// cut a message short so the next event lands in its data slots
				last_status = 8'($urandom_range(8'hEF, 8'h80));
				push_byte(last_status);
				if ($urandom_range(1))
					push_byte(8'($urandom_range(127)));
			end else begin
				b = 8'($urandom_range(255));
				push_byte(b, $urandom_range(99) < 20);
				if (b[7])
					last_status = b;
			end
		end
	endtask

	task automatic run_phase(input logic muted, input int scale, input int spct, input int rpct,
		input int count, input bit hold);
		settle();
		write_reg(CFG_NOTES_MUTED, CFG_DATA_W'(muted));
		write_reg(CFG_TICK_SCALE, CFG_DATA_W'(scale));
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		hold_req      = hold;
		run_random(count);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 11;
		recv_idle_pct = 52;

		// running status zero from reset, second data top bit ends without delta
		push_byte(8'h00, 1'b1); push_byte(8'h80); push_byte(8'hFF);
		// program change keeps a full first data byte, two-byte delta
		push_byte(8'hC5); push_byte(8'h80); push_byte(8'h81); push_byte(8'h01);
		// escape with zero length, zero delta; then running escape with length 1
		push_byte(8'hF7); push_byte(8'h00); push_byte(8'h00);
		push_byte(8'h01); push_byte(8'hAA); push_byte(8'h01);
		// end of track, then a data byte under running status FF
		push_byte(8'hFF); push_byte(8'h12);
		// restart mid-message, largest delta
		push_byte(8'h9F); push_byte(8'h40);
		push_byte(8'hE0, 1'b1); push_byte(8'h7F); push_byte(8'h7F);
		push_byte(8'hFF); push_byte(8'h7F);

		settle();
		write_reg(CFG_NOTES_MUTED, CFG_DATA_W'(1));
		write_reg(CFG_TICK_SCALE, CFG_DATA_W'(0));
		// muted note on, nonzero delta with zero scale
		push_byte(8'h90); push_byte(8'h3C); push_byte(8'h40); push_byte(8'h05);

		run_phase(1'b0, 1, 11, 52, 300, 1'b0);
		run_phase(1'b1, 100, 11, 52, 300, 1'b0);
		run_phase(1'b0, 127, 52, 11, 300, 1'b0);
		run_phase(1'b1, 0, 52, 11, 200, 1'b0);
		run_phase(1'b0, 10, 0, 0, 500, 1'b1);
		settle();

		$display("Covered %0d track bytes under seven mute/scale settings, with a long result stall.",
			bytes_sent);
		$display("Checked %0d messages, %0d waits and %0d track ends.",
			msg_count, wait_count, end_count);
		if (fail_count == 0 && pending == 0)
			$display("tb_midi_event_stream_parser_core passed");
		else
			$display("tb_midi_event_stream_parser_core failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/mesp_pkg.sv
sv/mesp_in_stage.sv
sv/mesp_parser.sv
sv/mesp_out_stage.sv
sv/midi_event_stream_parser_core.sv
tb/sv/midi_result_checker.sv
tb/sv/tb_midi_event_stream_parser_core.sv
